// ----- rtl/core/jos_pkg.sv -----
// ----------------------------------------------------------------------------
// jos_pkg
// Shared types, constants and a helper function of the Josephus elimination
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package jos_pkg;

  localparam int MaxMembers  = 64;
  localparam int CircleLimit = (MaxMembers < 64) ? MaxMembers : 64;
  localparam int MapW        = 64;
  localparam int IdxW        = 6;
  localparam int CountW      = 7;
  localparam int StepW       = 8;
  localparam int StepBitW    = 3;
  localparam int AddrW       = 3;
  localparam int DataW       = 32;

  localparam logic RegIdxStep = 1'b0;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              order;
  } jos_job_t;

  typedef struct packed {
    logic     valid;
    jos_job_t job;
  } jos_req_t;

  typedef enum logic [2:0] {
    StIdle,
    StMod,
    StWalk,
    StEmit,
    StDrop,
    StSurv
  } jos_state_e;

  // Next set bit after pos, wrapping; pos itself if it is the only one set.
  function automatic logic [IdxW-1:0] find_next(input logic [MapW-1:0] map,
                                                input logic [IdxW-1:0] pos);
    logic [MapW-1:0] above;
    logic [IdxW-1:0] hi_idx;
    logic [IdxW-1:0] lo_idx;
    above  = map & ~((MapW'(2) << pos) - MapW'(1));
    hi_idx = '0;
    lo_idx = '0;
    for (int i = MapW - 1; i >= 0; i--) begin
      if (above[i]) begin
        hi_idx = IdxW'(i);
      end
      if (map[i]) begin
        lo_idx = IdxW'(i);
      end
    end
    return (|above) ? hi_idx : lo_idx;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/josephus_elimination.sv -----
// ----------------------------------------------------------------------------
// josephus_elimination
// Josephus elimination: for each request of n members, reports the removal
// order (optionally) and the survivor for the configured counting step.
//
// Usage: a request beat carries member_count_i and report_order_i on the
// in_valid_i/in_ready_o channel. Results leave on out_valid_o/out_ready_i,
// one beat per removed member when report_order_i is set, then one beat for
// the survivor with is_survivor_o and last_o high. The step register sits at
// APB address 0. It must be written only while the block is idle; the
// block itself does not enforce this.
// Each removal runs a bit-serial remainder of adv = (step - 1) mod the
// living count (zero for step 0), walks the circle one living member per
// cycle for adv members, removes the member, and emits it when removals
// are reported. A single member goes from idle straight to the survivor
// state, which registers its survivor beat.
// A two-entry request queue lets new requests be taken while one is worked
// on; the engine handles one request at a time.
// Reset clears the queue and the engine and sets the step to 1. When the
// receiver stalls, the engine holds its result and pauses.
// ----------------------------------------------------------------------------
`default_nettype none

module josephus_elimination
  import jos_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [DataW-1:0]  pwdata,
  output logic      [DataW-1:0]  prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [CountW-1:0] member_count_i,
  input  wire logic              report_order_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [CountW-1:0] member_o,
  output logic                   is_survivor_o,
  output logic                   last_o
);

  logic [StepW-1:0] step_q, step_d;
  logic             step_wr;
  jos_req_t         req;
  logic             pop;

  assign pready  = 1'b1;
  assign step_wr = psel && penable && pwrite && (paddr[2] == RegIdxStep);
  assign step_d  = step_wr ? pwdata[StepW-1:0] : step_q;
  assign prdata  = (paddr[2] == RegIdxStep) ? {{(DataW - StepW){1'b0}}, step_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepW'(1);
    end else begin
      step_q <= step_d;
    end
  end

  jos_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .member_count_i (member_count_i),
    .report_order_i (report_order_i),
    .req_o          (req),
    .pop_i          (pop)
  );

  jos_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step_q),
    .req_i         (req),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .member_o      (member_o),
    .is_survivor_o (is_survivor_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/jos_front.sv -----
// ----------------------------------------------------------------------------
// jos_front
// Accepts requests, clamps the member count and holds them in a two-entry
// queue for the elimination engine.
// ----------------------------------------------------------------------------
`default_nettype none

module jos_front
  import jos_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [CountW-1:0] member_count_i,
  input  wire logic              report_order_i,
  output jos_req_t               req_o,
  input  wire logic              pop_i
);

  jos_job_t   q_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;
  jos_job_t   job_in;

  always_comb begin
    job_in.order = report_order_i;
    if (member_count_i == '0) begin
      job_in.count = CountW'(1);
    end else if (member_count_i > CountW'(CircleLimit)) begin
      job_in.count = CountW'(CircleLimit);
    end else begin
      job_in.count = member_count_i;
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = pop_i && (cnt_q != 2'd0);
  assign req_o.valid = (cnt_q != 2'd0);
  assign req_o.job   = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= job_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/jos_engine.sv -----
// ----------------------------------------------------------------------------
// jos_engine
// Runs one elimination at a time: reduces the step less one modulo the living count
// bit by bit, walks the circle one living member per cycle and drives the
// registered result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module jos_engine
  import jos_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [StepW-1:0]  step_i,
  input  wire jos_req_t          req_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [CountW-1:0]      member_o,
  output logic                   is_survivor_o,
  output logic                   last_o
);

  jos_state_e           state_q, state_d;
  logic [MapW-1:0]      alive_q, alive_d;
  logic [IdxW-1:0]      pos_q, pos_d;
  logic [CountW-1:0]    rem_q, rem_d;
  logic                 order_q, order_d;
  logic [IdxW-1:0]      rmd_q, rmd_d;
  logic [StepBitW-1:0]  bit_q, bit_d;
  logic                 out_valid_q, out_valid_d;
  logic [CountW-1:0]    member_q, member_d;
  logic                 surv_q, surv_d;

  logic [StepW-1:0]     adv_base;
  logic [CountW-1:0]    trial;
  logic [IdxW-1:0]      trial_rmd;
  logic [MapW-1:0]      alive_init;
  logic [MapW-1:0]      alive_drop;
  logic                 out_free;

  assign adv_base   = (step_i == '0) ? '0 : step_i - StepW'(1);
  assign trial      = {rmd_q, adv_base[bit_q]};
  assign trial_rmd  = (trial >= rem_q) ? IdxW'(trial - rem_q) : IdxW'(trial);
  assign alive_init = (req_i.job.count >= CountW'(MapW)) ? '1
                    : ((MapW'(1) << req_i.job.count) - MapW'(1));
  assign alive_drop = alive_q & ~(MapW'(1) << pos_q);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          state_d = (req_i.job.count == CountW'(1)) ? StSurv : StMod;
        end
      end
      StMod: begin
        if (bit_q == '0) begin
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (rmd_q == '0) begin
          state_d = order_q ? StEmit : StDrop;
        end
      end
      StEmit: begin
        if (out_free) begin
          state_d = StDrop;
        end
      end
      StDrop: begin
        state_d = (rem_q == CountW'(2)) ? StSurv : StMod;
      end
      StSurv: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    alive_d     = alive_q;
    pos_d       = pos_q;
    rem_d       = rem_q;
    order_d     = order_q;
    rmd_d       = rmd_q;
    bit_d       = bit_q;
    member_d    = member_q;
    surv_d      = surv_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          pop_o   = 1'b1;
          alive_d = alive_init;
          pos_d   = '0;
          rem_d   = req_i.job.count;
          order_d = req_i.job.order;
          rmd_d   = '0;
          bit_d   = '1;
        end
      end
      StMod: begin
        rmd_d = trial_rmd;
        bit_d = bit_q - StepBitW'(1);
      end
      StWalk: begin
        if (rmd_q != '0) begin
          pos_d = find_next(alive_q, pos_q);
          rmd_d = rmd_q - IdxW'(1);
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          member_d    = {1'b0, pos_q} + CountW'(1);
          surv_d      = 1'b0;
        end
      end
      StDrop: begin
        alive_d = alive_drop;
        rem_d   = rem_q - CountW'(1);
        pos_d   = find_next(alive_drop, pos_q);
        rmd_d   = '0;
        bit_d   = '1;
      end
      StSurv: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          member_d    = {1'b0, pos_q} + CountW'(1);
          surv_d      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    alive_q  <= alive_d;
    pos_q    <= pos_d;
    rem_q    <= rem_d;
    order_q  <= order_d;
    rmd_q    <= rmd_d;
    bit_q    <= bit_d;
    member_q <= member_d;
    surv_q   <= surv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign member_o      = member_q;
  assign is_survivor_o = surv_q;
  assign last_o        = surv_q;

  a_alive_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (alive_q != '0))
    else $error("engine busy with an empty circle");

  a_walk_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> ({1'b0, rmd_q} < rem_q))
    else $error("walk count not below living count");

  a_pos_alive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit || state_q == StSurv || state_q == StDrop) |-> alive_q[pos_q])
    else $error("selected member is not alive");

  a_surv_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSurv) |-> (rem_q == CountW'(1)))
    else $error("survivor reported with more than one member left");

endmodule

`default_nettype wire

// ----- dv/josephus_elimination_test.sv -----
// ----------------------------------------------------------------------------
// josephus_elimination_test
// Self-checking bench for the Josephus elimination block. Requests are queued
// by a stimulus sequence, driven by a clocked driver and checked by a monitor
// that recomputes each removal order for the current step setting. The step
// register is rewritten between phases over its extremes and random values,
// while the request and result channels idle and stall at random.
// ----------------------------------------------------------------------------

module josephus_elimination_test;
  import jos_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 40000;
  localparam int SettleCycles  = 100;
  localparam int HoldCycles    = 400;
  localparam int PrintLimit    = 100;

  typedef enum {
    PACE_FREE,
    PACE_SEND_SLOW,
    PACE_RECV_SLOW,
    PACE_BOTH_SLOW
  } pace_e;

  typedef struct packed {
    logic [CountW-1:0] member;
    logic              is_survivor;
    logic              last;
  } member_beat_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [AddrW-1:0]  paddr          = '0;
  logic [DataW-1:0]  pwdata         = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [CountW-1:0] member_count_i = '0;
  logic              report_order_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [CountW-1:0] member_o;
  logic              is_survivor_o;
  logic              last_o;

  jos_job_t     circle_jobs[$];
  member_beat_t awaited_members[$];
  logic [StepW-1:0] step_cfg = StepW'(1);
  pace_e pace = PACE_FREE;
  int    mismatches = 0;
  int    quiet_cycles = 0;
  logic  hold_kick = 1'b0;
  logic  hold_seen = 1'b0;
  int    hold_left = 0;

  josephus_elimination uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .member_count_i (member_count_i),
    .report_order_i (report_order_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .member_o       (member_o),
    .is_survivor_o  (is_survivor_o),
    .last_o         (last_o)
  );

  initial begin
    forever #1ns clk_i = ~clk_i;
  end

  function automatic int next_living(input logic [MapW-1:0] alive, input int from,
                                     input int n);
    int q;
    int i;
    q = from;
    for (i = 0; i < n; i++) begin
      q = (q + 1 >= n) ? 0 : q + 1;
      if (alive[q]) begin
        return q;
      end
    end
    return from;
  endfunction

  function automatic void predict_removals(input jos_job_t job);
    logic [MapW-1:0] alive;
    member_beat_t    beat;
    int n;
    int pos;
    int left;
    int adv_base;
    int adv;
    n = int'(job.count);
    if (n == 0) begin
      n = 1;
    end
    if (n > CircleLimit) begin
      n = CircleLimit;
    end
    alive    = (n >= MapW) ? '1 : (MapW'(1) << n) - MapW'(1);
    pos      = 0;
    left     = n;
    adv_base = (step_cfg == '0) ? 0 : int'(step_cfg) - 1;
    while (left > 1) begin
      adv = adv_base % left;
      repeat (adv) pos = next_living(alive, pos, n);
      if (job.order) begin
        beat.member      = CountW'(pos + 1);
        beat.is_survivor = 1'b0;
        beat.last        = 1'b0;
        awaited_members.push_back(beat);
      end
      alive[pos] = 1'b0;
      left--;
      pos = next_living(alive, pos, n);
    end
    beat.member      = CountW'(pos + 1);
    beat.is_survivor = 1'b1;
    beat.last        = 1'b1;
    awaited_members.push_back(beat);
  endfunction

  function automatic bit sender_idles();
    case (pace)
      PACE_SEND_SLOW: return $urandom_range(99) < 74;
      PACE_BOTH_SLOW: return $urandom_range(99) < 16;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (pace)
      PACE_RECV_SLOW: return $urandom_range(99) < 74;
      PACE_BOTH_SLOW: return $urandom_range(99) < 16;
      default:        return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PrintLimit) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  always @(posedge clk_i) begin : driver
    jos_job_t job;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (circle_jobs.size() != 0 && !sender_idles()) begin
        job = circle_jobs.pop_front();
        in_valid_i     <= 1'b1;
        member_count_i <= job.count;
        report_order_i <= job.order;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : receiver
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_seen   <= hold_kick;
      hold_left   <= 0;
    end else if (hold_kick != hold_seen) begin
      hold_seen   <= hold_kick;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !receiver_stalls();
    end
  end

  always @(posedge clk_i) begin : monitor
    member_beat_t want;
    jos_job_t     job;
    bit           moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (awaited_members.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, member %0d", member_o));
        end else begin
          want = awaited_members.pop_front();
          if (member_o !== want.member) begin
            report_mismatch($sformatf("member %0d, wanted %0d", member_o, want.member));
          end
          if (is_survivor_o !== want.is_survivor) begin
            report_mismatch($sformatf("is_survivor %0b, wanted %0b", is_survivor_o,
                                      want.is_survivor));
          end
          if (last_o !== want.last) begin
            report_mismatch($sformatf("last %0b, wanted %0b", last_o, want.last));
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        moved     = 1'b1;
        job.count = member_count_i;
        job.order = report_order_i;
        predict_removals(job);
      end
      if (psel && penable && pwrite && pready) begin
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic queue_job(input int count, input bit order);
    jos_job_t job;
    job.count = CountW'(count);
    job.order = order;
    circle_jobs.push_back(job);
  endtask

  task automatic queue_random(input int items);
    int pick;
    int count;
    repeat (items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        count = $urandom_range(12, 1);
      end else if (pick < 85) begin
        count = $urandom_range(64, 13);
      end else if (pick < 95) begin
        count = $urandom_range(127, 65);
      end else begin
        count = 0;
      end
      queue_job(count, $urandom_range(99) < 70);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (circle_jobs.size() != 0 || in_valid_i || awaited_members.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_step(input logic [StepW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegIdxStep, 2'b00};
    pwdata  <= DataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    step_cfg = value;
    @(negedge clk_i);
  endtask

  task automatic random_phase(input logic [StepW-1:0] value, input pace_e p,
                              input int items);
    drain();
    write_step(value);
    pace = p;
    queue_random(items);
  endtask

  initial begin : sequencer
    int i;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    pace = PACE_FREE;
    queue_job(1, 1'b1);
    queue_job(0, 1'b1);
    queue_job(0, 1'b0);
    queue_job(2, 1'b1);
    queue_job(2, 1'b0);
    queue_job(7, 1'b1);
    queue_job(64, 1'b1);
    queue_job(127, 1'b0);
    queue_job(65, 1'b1);
    queue_job(100, 1'b1);

    drain();
    write_step(StepW'(0));
    queue_job(5, 1'b1);
    queue_job(1, 1'b1);
    queue_job(64, 1'b0);

    drain();
    write_step(StepW'(255));
    queue_job(64, 1'b1);
    queue_job(10, 1'b1);
    queue_job(3, 1'b1);
    queue_job(127, 1'b1);

    drain();
    write_step(StepW'(3));
    queue_job(41, 1'b1);
    queue_job(6, 1'b0);

    random_phase(StepW'(2), PACE_FREE, 30);
    random_phase(StepW'($urandom_range(255, 0)), PACE_SEND_SLOW, 30);
    random_phase(StepW'(255), PACE_RECV_SLOW, 30);
    random_phase(StepW'(0), PACE_BOTH_SLOW, 30);

    // Long receiver hold while requests keep coming, so the input backs up.
    drain();
    write_step(StepW'(4));
    pace = PACE_FREE;
    hold_kick <= ~hold_kick;
    for (i = 0; i < 24; i++) begin
      queue_job($urandom_range(10, 3), 1'b1);
    end

    // Sender waits for every result before continuing.
    random_phase(StepW'($urandom_range(255, 0)), PACE_BOTH_SLOW, 20);
    drain();
    queue_random(20);

    random_phase(StepW'(128), PACE_SEND_SLOW, 30);
    random_phase(StepW'($urandom_range(255, 0)), PACE_FREE, 30);
    random_phase(StepW'(1), PACE_BOTH_SLOW, 30);

    drain();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
